// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");
`endif

// File: rtl/sprf_pkg.sv
// Package with sizes and codes shared by the primitive root finder.
`timescale 1ns / 1ps
package sprf_pkg;
	localparam int MODULUS_BITS_DEF = 16;
	localparam int MAX_FACTORS_DEF = 6;
	localparam int DATA_BYTES = (MODULUS_BITS_DEF + 7) / 8;
	localparam int OUT_BYTES = (MODULUS_BITS_DEF + 1 + 7) / 8;

	// Operation codes for the bit-serial arithmetic unit.
	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1
	} arith_op_t;
endpackage

// File: rtl/sprf_arith.sv
// Bit-serial modular multiplier and restoring divider, one bit per cycle.
`timescale 1ns / 1ps
module sprf_arith #(
	parameter int W = sprf_pkg::MODULUS_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sprf_pkg::arith_op_t op,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	input  logic [W-1:0]      m,
	output logic              done,
	output logic [W-1:0]      quo,
	output logic [W-1:0]      res
);
	import sprf_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W:0]    acc_q;
	logic [W-1:0]  sh_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  m_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	arith_op_t     op_q;
	logic [W+1:0]  dbl;
	logic [W+1:0]  red1;
	logic [W+1:0]  red2;
	logic [W:0]    dtr;
	logic          top_bit;

	assign top_bit = sh_q[W-1];
	// Multiply step: acc = 2*acc + bit*b, reduced twice below m.
	always_comb begin
		dbl = {acc_q, 1'b0} + (top_bit ? {2'b00, b_q} : '0);
		red1 = (dbl >= {2'b00, m_q}) ? dbl - {2'b00, m_q} : dbl;
		red2 = (red1 >= {2'b00, m_q}) ? red1 - {2'b00, m_q} : red1;
		dtr = {acc_q[W-1:0], top_bit};
	end

	// Sequencer: W steps per operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			sh_q <= a;
			b_q <= b;
			m_q <= m;
			op_q <= op;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				acc_q <= red2[W:0];
				sh_q <= {sh_q[W-2:0], 1'b0};
			end else begin
				if (dtr >= {1'b0, m_q}) begin
					acc_q <= dtr - {1'b0, m_q};
					sh_q <= {sh_q[W-2:0], 1'b1};
				end else begin
					acc_q <= dtr;
					sh_q <= {sh_q[W-2:0], 1'b0};
				end
			end
		end
	end

	assign done = done_q;
	assign res = acc_q[W-1:0];
	assign quo = sh_q;
endmodule

// File: rtl/sprf_ctrl.sv
// Sequencer for factoring, exponent generation and the candidate search.
`timescale 1ns / 1ps
module sprf_ctrl #(
	parameter int W = sprf_pkg::MODULUS_BITS_DEF,
	parameter int NF = sprf_pkg::MAX_FACTORS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] p_in,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] root,
	output logic         ok
);
	import sprf_pkg::*;

	localparam int FW = $clog2(NF + 1);
	localparam int IW = (NF > 1) ? $clog2(NF) : 1;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_DDIV  = 9'b000000010,
		ST_DMOD  = 9'b000000100,
		ST_FEXP  = 9'b000001000,
		ST_PINIT = 9'b000010000,
		ST_PMUL  = 9'b000100000,
		ST_PSQ   = 9'b001000000,
		ST_NEXT  = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t        state_q;
	logic [W-1:0]  p_q, n_q, d_q, g_q, pw_q, bs_q, e_q;
	logic [W-1:0]  fl_q [NF];
	logic [FW-1:0] fc_q;
	logic [IW-1:0] fi_q;
	logic          had_q;
	logic          issued_q;
	logic [W-1:0]  root_q;
	logic          ok_q;
	logic          start;
	arith_op_t     op;
	logic [W-1:0]  a, b, m, quo, res;
	logic          done;

	sprf_arith #(.W(W)) u_arith (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op),
		.a(a), .b(b), .m(m), .done(done), .quo(quo), .res(res)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign root = root_q;
	assign ok = ok_q;

	// Operand selection and issue of one operation per waiting state.
	always_comb begin
		start = 1'b0;
		op = OP_MUL;
		a = pw_q;
		b = bs_q;
		m = p_q;
		case (state_q)
			ST_DDIV: begin
				start = 1'b1;
				op = OP_DIV;
				a = n_q;
				m = d_q;
			end
			ST_FEXP: begin
				start = !issued_q;
				op = OP_DIV;
				a = p_q - 1'b1;
				m = fl_q[fi_q];
			end
			ST_PMUL: start = !issued_q && e_q[0];
			ST_PSQ: begin
				start = !issued_q;
				a = bs_q;
			end
			default: ;
		endcase
	end

	// Main sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			p_q <= '0;
			n_q <= '0;
			d_q <= '0;
			for (int i = 0; i < NF; i++)
				fl_q[i] <= '0;
			fc_q <= '0;
			fi_q <= '0;
			g_q <= '0;
			pw_q <= '0;
			bs_q <= '0;
			e_q <= '0;
			ok_q <= 1'b0;
			root_q <= '0;
			had_q <= 1'b0;
			issued_q <= 1'b0;
		end else begin
			// An issued operation stays pending until the unit reports done.
			if (start)
				issued_q <= 1'b1;
			else if (done)
				issued_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) begin
					p_q <= p_in;
					fc_q <= '0;
					root_q <= '0;
					ok_q <= 1'b0;
					if (p_in == W'(2)) begin
						root_q <= W'(1);
						ok_q <= 1'b1;
						state_q <= ST_OUT;
					end else if (p_in < W'(2)) begin
						state_q <= ST_OUT;
					end else begin
						n_q <= p_in - 1'b1;
						d_q <= W'(2);
						had_q <= 1'b0;
						state_q <= ST_DDIV;
					end
				end
				ST_DDIV: state_q <= ST_DMOD;
				// Trial division of n by d; a quotient below d means d*d exceeds n.
				ST_DMOD: if (done) begin
					if (res == '0) begin
						if (!had_q && fc_q < FW'(NF)) begin
							fl_q[fc_q[IW-1:0]] <= d_q;
							fc_q <= fc_q + 1'b1;
						end
						had_q <= 1'b1;
						n_q <= quo;
						state_q <= ST_DDIV;
					end else if (had_q || quo >= d_q) begin
						d_q <= d_q + 1'b1;
						had_q <= 1'b0;
						state_q <= ST_DDIV;
					end else begin
						// What is left of n is one or a prime factor.
						if (n_q > W'(1) && fc_q < FW'(NF)) begin
							fl_q[fc_q[IW-1:0]] <= n_q;
							fc_q <= fc_q + 1'b1;
						end
						fi_q <= '0;
						g_q <= W'(2);
						state_q <= (n_q > W'(1) && fc_q < FW'(NF)) || fc_q != '0
							? ST_FEXP : ST_NEXT;
						if (!(n_q > W'(1) && fc_q < FW'(NF)) && fc_q == '0)
							g_q <= p_q;
					end
				end
				// Exponent (p-1)/q, then the power.
				ST_FEXP: if (done) begin
					e_q <= quo;
					state_q <= ST_PINIT;
				end
				ST_PINIT: begin
					pw_q <= W'(1);
					bs_q <= g_q;
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					if (e_q == '0) begin
						if (pw_q == W'(1)) begin
							g_q <= g_q + 1'b1;
							fi_q <= '0;
							state_q <= ST_NEXT;
						end else if (FW'(fi_q) + 1'b1 >= fc_q) begin
							root_q <= g_q;
							ok_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							fi_q <= fi_q + 1'b1;
							state_q <= ST_FEXP;
						end
					end else if (!e_q[0]) begin
						state_q <= ST_PSQ;
					end else if (done) begin
						pw_q <= res;
						state_q <= ST_PSQ;
					end
				end
				ST_PSQ: if (done) begin
					bs_q <= res;
					e_q <= e_q >> 1;
					state_q <= ST_PMUL;
				end
				ST_NEXT: begin
					if (g_q >= p_q) state_q <= ST_OUT;
					else if (fc_q == '0) begin
						root_q <= g_q;
						ok_q <= 1'b1;
						state_q <= ST_OUT;
					end else state_q <= ST_FEXP;
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/smallest_primitive_root_finder.sv
// Top level of the smallest primitive root finder.
// One modulus p in, one result out. p-1 is factored by trial division, then
// candidates from 2 are tested with square-and-multiply powers. Every modular
// product and every division goes through one bit-serial unit. A modulus p
// below three is answered without that work; otherwise the work grows with the
// trial divisors up to the square root of p-1 and with the count of candidates
// and factors tried.
// The next item is taken once the result has been delivered.
`timescale 1ns / 1ps
module smallest_primitive_root_finder #(
	parameter int MODULUS_BITS = sprf_pkg::MODULUS_BITS_DEF,
	parameter int MAX_FACTORS = sprf_pkg::MAX_FACTORS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// prime_modulus
	input  logic [((MODULUS_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// primitive_root, found
	output logic [((MODULUS_BITS+8)/8)*8-1:0] m_axis_tdata
);
	import sprf_pkg::*;

	localparam int OW = ((MODULUS_BITS + 8) / 8) * 8;

	logic [MODULUS_BITS-1:0] root;
	logic                    ok;

	// Core sequencer with its arithmetic unit.
	sprf_ctrl #(.W(MODULUS_BITS), .NF(MAX_FACTORS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.p_in(s_axis_tdata[MODULUS_BITS-1:0]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.root(root), .ok(ok)
	);

	assign m_axis_tdata = OW'({ok, root});
endmodule

// File: rtl/sprf_checker.sv
// Port-level checker for the primitive root finder, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sprf_checker #(
	parameter int W = 16
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [((W+8)/8)*8-1:0]    m_axis_tdata
);
	`ASSERT_IMPL(a_excl, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ASSERT_IMPL(a_nf, clk, arst_n, m_axis_tvalid && !m_axis_tdata[W], m_axis_tdata[W-1:0] == '0)
	`ASSERT_NEXT(a_busy, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind smallest_primitive_root_finder sprf_checker #(.W(MODULUS_BITS)) u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
